FILE: sv/rgbled_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgbled_pkg
// shared types and constants of the rgb led blink engine
// ----------------------------------------------------------------------------
package rgbled_pkg;

    localparam int CHANNELS_PER_LED = 3;
    localparam int BYTE_W           = 8;
    localparam int TICKS_W          = 16;
    localparam int COUNT_W          = 17;
    localparam int CHAN_W           = 6;

    typedef enum logic [1:0] {
        OP_SET_COLOR = 2'd0,
        OP_SET_MODE  = 2'd1,
        OP_SET_BLINK = 2'd2,
        OP_TICK      = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_ON    = 2'd1,
        MODE_BLINK = 2'd2,
        MODE_PULSE = 2'd3
    } t_mode;

    // one table entry per led
    typedef struct packed {
        t_mode               mode;
        logic [TICKS_W-1:0]  on_ticks;
        logic [TICKS_W-1:0]  off_ticks;
        logic [COUNT_W-1:0]  tick_count;
        logic                lit;
        logic [BYTE_W-1:0]   red;
        logic [BYTE_W-1:0]   green;
        logic [BYTE_W-1:0]   blue;
    } t_led_entry;

endpackage
`default_nettype wire

FILE: sv/rgbled_update.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgbled_update
// per-led mode step applied to one table entry on a tick
// ----------------------------------------------------------------------------
module rgbled_update
    import rgbled_pkg::*;
(
    input  t_led_entry i_entry,
    output t_led_entry o_entry
);

    always_comb begin
        logic [COUNT_W-1:0] cnt;
        logic               lit;
        logic [COUNT_W-1:0] inc_off;
        logic [COUNT_W-1:0] inc_on;
        logic               lit_phase;

        cnt       = i_entry.tick_count;
        lit       = i_entry.lit;
        lit_phase = 1'b0;
        inc_off   = cnt + COUNT_W'(1);

        case (i_entry.mode)
            MODE_ON: begin
                lit = 1'b1;
            end
            MODE_BLINK: begin
                // dark phase count
                if (!lit) begin
                    if (inc_off > {1'b0, i_entry.off_ticks}) begin
                        lit = 1'b1;
                        cnt = '0;
                    end else begin
                        cnt = inc_off;
                    end
                end
                lit_phase = 1'b1;
            end
            MODE_PULSE: begin
                if (!lit) begin
                    lit = 1'b1;
                    cnt = '0;
                end
                lit_phase = 1'b1;
            end
            default: begin
                lit = 1'b0;
            end
        endcase

        // lit phase count, may follow the dark phase in the same tick
        inc_on = cnt + COUNT_W'(1);
        if (lit_phase && lit) begin
            if (inc_on > {1'b0, i_entry.on_ticks}) begin
                lit = 1'b0;
                cnt = '0;
            end else begin
                cnt = inc_on;
            end
        end

        o_entry            = i_entry;
        o_entry.tick_count = cnt;
        o_entry.lit        = lit;
    end

endmodule
`default_nettype wire

FILE: sv/rgb_led_blink_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_led_blink_engine
// led table with per-led color, mode and blink timing; a tick steps every led
// and streams one byte per color channel
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake                | payload
//  ----------+-----------+--------------------------+-----------------------------------
//  command   | in        | start high, busy low     | i_operation, i_led_index, i_red,
//            |           |                          | i_green, i_blue, i_mode_value,
//            |           |                          | i_on_ticks, i_off_ticks
//  channel   | out       | o_strobe, one cycle each | o_channel_index, o_channel_byte,
//            |           |                          | o_last_channel
//
//  a write transaction reads the led entry, then modifies and writes it back;
//  a write to an absent led is dropped at acceptance and the block stays idle
//  a tick walks the leds through the single table memory: each led is read
//  once, updated and written back while its three channel bytes go out on
//  consecutive cycles
//  reset clears the fsm and the per-led valid bits; an entry never written
//  reads as all zero, so no clearing pass is needed
//  results are never stalled: o_strobe runs on every cycle of a tick's burst
//
module rgb_led_blink_engine
    import rgbled_pkg::*;
#(
    parameter int LED_COUNT = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,

    input  wire                 start,
    output logic                busy,
    input  wire  [1:0]          i_operation,
    input  wire  [3:0]          i_led_index,
    input  wire  [BYTE_W-1:0]   i_red,
    input  wire  [BYTE_W-1:0]   i_green,
    input  wire  [BYTE_W-1:0]   i_blue,
    input  wire  [1:0]          i_mode_value,
    input  wire  [TICKS_W-1:0]  i_on_ticks,
    input  wire  [TICKS_W-1:0]  i_off_ticks,

    output logic                o_strobe,
    output logic [CHAN_W-1:0]   o_channel_index,
    output logic [BYTE_W-1:0]   o_channel_byte,
    output logic                o_last_channel
);

    localparam int LED_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_WRITE = 3'b010,
        S_TICK  = 3'b100
    } t_state;

    // fsm and tick walk
    t_state             r_state,  n_state;
    logic [LED_W-1:0]   r_led,    n_led;
    logic [1:0]         r_col,    n_col;
    logic [CHAN_W-1:0]  r_chan,   n_chan;

    // output register
    logic               r_strobe, n_strobe;
    logic [CHAN_W-1:0]  r_out_chan, n_out_chan;
    logic [BYTE_W-1:0]  r_out_byte, n_out_byte;
    logic               r_out_last, n_out_last;

    // latched command payload
    t_op                r_op;
    logic [LED_W-1:0]   r_idx;
    logic [BYTE_W-1:0]  r_red, r_green, r_blue;
    t_mode              r_mode_val;
    logic [TICKS_W-1:0] r_on, r_off;

    // updated led held for its green and blue bytes
    logic               r_lit_l;
    logic [BYTE_W-1:0]  r_green_l, r_blue_l;

    // table memory
    t_led_entry         r_mem [LED_COUNT];
    logic [LED_COUNT-1:0] r_valid;
    t_led_entry         r_rd_data;
    logic               r_rd_ok;

    logic               mem_rd_en;
    logic [LED_W-1:0]   mem_rd_addr;
    logic               mem_wr_en;
    logic [LED_W-1:0]   mem_wr_addr;
    t_led_entry         mem_wr_data;

    t_led_entry         cur_entry;
    t_led_entry         upd_entry;
    t_led_entry         wr_entry;

    logic               accept;
    logic               idx_ok;
    logic [LED_W-1:0]   cmd_idx;
    logic               is_last_led;
    logic               tick_first;

    assign busy        = (r_state != S_IDLE);
    assign accept      = start && !busy;
    assign idx_ok      = ({1'b0, i_led_index} < 5'(LED_COUNT));
    assign cmd_idx     = LED_W'(i_led_index);
    assign is_last_led = (r_led == LED_W'(LED_COUNT - 1));
    assign tick_first  = (r_state == S_TICK) && (r_col == 2'd0);

    // entries never written read as the reset value
    assign cur_entry = r_rd_ok ? r_rd_data : '0;

    rgbled_update u_update (
        .i_entry (cur_entry),
        .o_entry (upd_entry)
    );

    // read-modify-write of a command transaction
    always_comb begin
        wr_entry = cur_entry;
        case (r_op)
            OP_SET_COLOR: begin
                wr_entry.red   = r_red;
                wr_entry.green = r_green;
                wr_entry.blue  = r_blue;
            end
            OP_SET_MODE: begin
                wr_entry.mode = r_mode_val;
            end
            OP_SET_BLINK: begin
                wr_entry.on_ticks  = r_on;
                wr_entry.off_ticks = r_off;
            end
            default: begin
                wr_entry = cur_entry;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_led       = r_led;
        n_col       = r_col;
        n_chan      = r_chan;
        n_strobe    = 1'b0;
        n_out_chan  = r_out_chan;
        n_out_byte  = r_out_byte;
        n_out_last  = 1'b0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_led;
        mem_wr_data = upd_entry;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (t_op'(i_operation) == OP_TICK) begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = '0;
                        n_led       = '0;
                        n_col       = 2'd0;
                        n_chan      = '0;
                        n_state     = S_TICK;
                    end else if (idx_ok) begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = cmd_idx;
                        n_state     = S_WRITE;
                    end
                end
            end
            S_WRITE: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_idx;
                mem_wr_data = wr_entry;
                n_state     = S_IDLE;
            end
            S_TICK: begin
                n_strobe   = 1'b1;
                n_out_chan = r_chan;
                n_chan     = r_chan + CHAN_W'(1);
                case (r_col)
                    2'd0: begin
                        // entry of r_led is on the read port: step it and write back
                        mem_wr_en  = 1'b1;
                        n_out_byte = upd_entry.lit ? upd_entry.red : '0;
                        n_col      = 2'd1;
                    end
                    2'd1: begin
                        n_out_byte = r_lit_l ? r_green_l : '0;
                        // fetch the next led so it lands for its red byte
                        if (!is_last_led) begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = r_led + LED_W'(1);
                        end
                        n_col = 2'd2;
                    end
                    2'd2: begin
                        n_out_byte = r_lit_l ? r_blue_l : '0;
                        if (is_last_led) begin
                            n_out_last = 1'b1;
                            n_state    = S_IDLE;
                        end else begin
                            n_led = r_led + LED_W'(1);
                            n_col = 2'd0;
                        end
                    end
                    default: begin
                        n_strobe = 1'b0;
                        n_chan   = r_chan;
                        n_col    = 2'd0;
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_led    <= '0;
            r_col    <= 2'd0;
            r_chan   <= '0;
            r_strobe <= 1'b0;
            r_out_last <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_led    <= n_led;
            r_col    <= n_col;
            r_chan   <= n_chan;
            r_strobe <= n_strobe;
            r_out_last <= n_out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_chan <= n_out_chan;
        r_out_byte <= n_out_byte;
    end

    // command payload capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op       <= t_op'(i_operation);
            r_idx      <= cmd_idx;
            r_red      <= i_red;
            r_green    <= i_green;
            r_blue     <= i_blue;
            r_mode_val <= t_mode'(i_mode_value);
            r_on       <= i_on_ticks;
            r_off      <= i_off_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_first) begin
            r_lit_l   <= upd_entry.lit;
            r_green_l <= upd_entry.green;
            r_blue_l  <= upd_entry.blue;
        end
    end

    // table memory, one read and one write port
    always_ff @(posedge i_clk) begin
        if (mem_wr_en) begin
            r_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en) begin
            r_rd_data <= r_mem[mem_rd_addr];
            r_rd_ok   <= r_valid[mem_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (mem_wr_en) begin
            r_valid[mem_wr_addr] <= 1'b1;
        end
    end

    assign o_strobe        = r_strobe;
    assign o_channel_index = r_out_chan;
    assign o_channel_byte  = r_out_byte;
    assign o_last_channel  = r_out_last;

`ifndef SYNTHESIS
    // bytes come only out of a tick walk
    a_strobe_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> $past(r_state == S_TICK))
        else $error("strobe outside a tick");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_out_last) |-> (r_out_chan == CHAN_W'(CHANNELS_PER_LED * LED_COUNT - 1)))
        else $error("last flag on wrong channel");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_out_last) |-> (r_state == S_IDLE))
        else $error("walk still running after last channel");

    a_burst_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && !r_out_last) |=>
            (r_strobe && (r_out_chan == CHAN_W'($past(r_out_chan) + CHAN_W'(1)))))
        else $error("channel burst broken");

    a_no_wr_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr))
        else $error("read and write of the same entry");
`endif

endmodule
`default_nettype wire

FILE: test/testbench.sv
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the rgb led blink engine: a directed opening and
// random led programs followed by ticks; a local model of the led table
// predicts every channel byte, and a monitor compares the streamed bytes in order
// ----------------------------------------------------------------------------
module testbench
    import rgbled_pkg::*;
;

    localparam int TB_LEDS       = 16;
    localparam int CHANNEL_COUNT = TB_LEDS * CHANNELS_PER_LED;
    localparam int RANDOM_ITEMS  = 235;
    // the last transactions go out back to back
    localparam int TAIL_ITEMS    = 40;
    // a tick streams one byte per channel; the drain wait adds slack on top
    localparam int DRAIN_CYCLES  = CHANNEL_COUNT + 8;
    // every item a tick with the longest gap, times several
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PRINT_LIMIT   = 40;

    // one command transaction as the driver presents it
    typedef struct {
        t_op                op;
        logic [3:0]         led;
        logic [BYTE_W-1:0]  red;
        logic [BYTE_W-1:0]  green;
        logic [BYTE_W-1:0]  blue;
        logic [1:0]         mode;
        logic [TICKS_W-1:0] on_t;
        logic [TICKS_W-1:0] off_t;
    } t_command;

    // one streamed channel byte
    typedef struct {
        logic [CHAN_W-1:0] chan_idx;
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_channel_beat;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #10 i_clk = ~i_clk;

    // dut inputs start at known values
    logic               start        = 1'b0;
    logic [1:0]         i_operation  = '0;
    logic [3:0]         i_led_index  = '0;
    logic [BYTE_W-1:0]  i_red        = '0;
    logic [BYTE_W-1:0]  i_green      = '0;
    logic [BYTE_W-1:0]  i_blue       = '0;
    logic [1:0]         i_mode_value = '0;
    logic [TICKS_W-1:0] i_on_ticks   = '0;
    logic [TICKS_W-1:0] i_off_ticks  = '0;

    logic               busy;
    logic               o_strobe;
    logic [CHAN_W-1:0]  o_channel_index;
    logic [BYTE_W-1:0]  o_channel_byte;
    logic               o_last_channel;

    rgb_led_blink_engine #(
        .LED_COUNT (TB_LEDS)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_led_index     (i_led_index),
        .i_red           (i_red),
        .i_green         (i_green),
        .i_blue          (i_blue),
        .i_mode_value    (i_mode_value),
        .i_on_ticks      (i_on_ticks),
        .i_off_ticks     (i_off_ticks),
        .o_strobe        (o_strobe),
        .o_channel_index (o_channel_index),
        .o_channel_byte  (o_channel_byte),
        .o_last_channel  (o_last_channel)
    );

    // ------------------------------------------------------------------
    // led table model, same reset state as the block
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0]  model_bright [CHANNEL_COUNT];
    t_mode              model_mode   [TB_LEDS];
    logic [TICKS_W-1:0] model_on     [TB_LEDS];
    logic [TICKS_W-1:0] model_off    [TB_LEDS];
    logic [COUNT_W-1:0] model_count  [TB_LEDS];
    logic               model_lit    [TB_LEDS];

    initial begin
        foreach (model_bright[i]) model_bright[i] = '0;
        for (int n = 0; n < TB_LEDS; n++) begin
            model_mode[n]  = MODE_OFF;
            model_on[n]    = '0;
            model_off[n]   = '0;
            model_count[n] = '0;
            model_lit[n]   = 1'b0;
        end
    end

    t_command      pending_commands[$];
    t_channel_beat expected_channels[$];

    int mismatch_count = 0;
    int accepted_count = 0;
    int total_items    = 0;
    int cycle_count    = 0;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    // lit half of blink and pulse: count up while lit, go dark past on time
    function automatic void run_lit_phase(input int n);
        if (model_lit[n]) begin
            model_count[n] = model_count[n] + 1'b1;
            if (model_count[n] > {1'b0, model_on[n]}) begin
                model_lit[n]   = 1'b0;
                model_count[n] = '0;
            end
        end
    endfunction

    function automatic void advance_led(input int n);
        case (model_mode[n])
            MODE_ON: begin
                model_lit[n] = 1'b1;
            end
            MODE_BLINK: begin
                // dark half first; lighting up clears the count and the
                // lit check then runs in the same tick
                if (!model_lit[n]) begin
                    model_count[n] = model_count[n] + 1'b1;
                    if (model_count[n] > {1'b0, model_off[n]}) begin
                        model_lit[n]   = 1'b1;
                        model_count[n] = '0;
                    end
                end
                run_lit_phase(n);
            end
            MODE_PULSE: begin
                if (!model_lit[n]) begin
                    model_lit[n]   = 1'b1;
                    model_count[n] = '0;
                end
                run_lit_phase(n);
            end
            default: begin
                model_lit[n] = 1'b0;
            end
        endcase
    endfunction

    // update the model for one accepted transaction and queue the bytes
    // that a tick streams out
    task automatic apply_command(input t_command cmd);
        t_channel_beat beat;
        int            base;
        base = int'(cmd.led) * CHANNELS_PER_LED;
        if (cmd.op != OP_TICK) begin
            // writes to leds beyond the table are dropped
            if (int'(cmd.led) < TB_LEDS) begin
                case (cmd.op)
                    OP_SET_COLOR: begin
                        model_bright[base]     = cmd.red;
                        model_bright[base + 1] = cmd.green;
                        model_bright[base + 2] = cmd.blue;
                    end
                    OP_SET_MODE: begin
                        model_mode[cmd.led] = t_mode'(cmd.mode);
                    end
                    default: begin
                        model_on[cmd.led]  = cmd.on_t;
                        model_off[cmd.led] = cmd.off_t;
                    end
                endcase
            end
        end else begin
            for (int n = 0; n < TB_LEDS; n++)
                advance_led(n);
            for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
                beat.chan_idx = CHAN_W'(ch);
                beat.data     = model_lit[ch / CHANNELS_PER_LED] ? model_bright[ch] : '0;
                beat.last     = (ch == CHANNEL_COUNT - 1);
                expected_channels.push_back(beat);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus construction
    // ------------------------------------------------------------------
    task automatic add_command(input t_op op, input int led,
                               input int red, input int green, input int blue,
                               input int mode, input int on_t, input int off_t);
        t_command cmd;
        cmd.op    = op;
        cmd.led   = 4'(led);
        cmd.red   = BYTE_W'(red);
        cmd.green = BYTE_W'(green);
        cmd.blue  = BYTE_W'(blue);
        cmd.mode  = 2'(mode);
        cmd.on_t  = TICKS_W'(on_t);
        cmd.off_t = TICKS_W'(off_t);
        pending_commands.push_back(cmd);
    endtask

    function automatic int random_byte();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return 0;
        if (pick == 1) return 255;
        return $urandom_range(0, 255);
    endfunction

    // mostly short times so leds actually cycle, now and then the extremes
    function automatic int random_ticks();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) return 0;
        if (pick == 1) return 65535;
        if (pick < 4) return $urandom_range(0, 65535);
        return $urandom_range(0, 6);
    endfunction

    task automatic add_random_command();
        int   pick;
        t_op  op;
        pick = $urandom_range(0, 99);
        if (pick < 40)      op = OP_TICK;
        else if (pick < 60) op = OP_SET_COLOR;
        else if (pick < 80) op = OP_SET_MODE;
        else                op = OP_SET_BLINK;
        add_command(op, $urandom_range(0, 15), random_byte(), random_byte(), random_byte(),
                    $urandom_range(0, 3), random_ticks(), random_ticks());
    endtask

    task automatic build_directed();
        // tick straight out of reset: every byte zero
        add_command(OP_TICK, 15, 255, 255, 255, 3, 65535, 65535);
        add_command(OP_SET_COLOR, 0, 255, 255, 255, 0, 0, 0);
        add_command(OP_SET_COLOR, 15, 8'hA5, 8'h5A, 8'hFF, 3, 65535, 65535);
        add_command(OP_SET_COLOR, 1, 1, 2, 3, 0, 0, 0);
        add_command(OP_SET_COLOR, 2, 10, 20, 30, 0, 0, 0);
        add_command(OP_SET_COLOR, 3, 200, 100, 50, 0, 0, 0);
        add_command(OP_SET_MODE, 0, 0, 0, 0, MODE_ON, 0, 0);
        add_command(OP_SET_MODE, 15, 0, 0, 0, MODE_PULSE, 0, 0);
        // blink with zero times: lights and goes dark in the same tick
        add_command(OP_SET_MODE, 1, 0, 0, 0, MODE_BLINK, 0, 0);
        add_command(OP_SET_MODE, 2, 0, 0, 0, MODE_OFF, 0, 0);
        add_command(OP_SET_BLINK, 3, 0, 0, 0, 0, 1, 2);
        add_command(OP_SET_MODE, 3, 0, 0, 0, MODE_BLINK, 0, 0);
        repeat (4) add_command(OP_TICK, 0, 0, 0, 0, 0, 0, 0);
        // widest on times: pulse stays lit, blink with zero off time lights and stays lit
        add_command(OP_SET_BLINK, 15, 0, 0, 0, 0, 65535, 65535);
        add_command(OP_SET_BLINK, 1, 0, 0, 0, 0, 65535, 0);
        repeat (2) add_command(OP_TICK, 7, 0, 0, 0, 0, 0, 0);
        add_command(OP_SET_MODE, 0, 0, 0, 0, MODE_OFF, 0, 0);
        add_command(OP_SET_COLOR, 0, 0, 0, 0, 0, 0, 0);
        // pulse with zero on time: dark again every tick
        add_command(OP_SET_BLINK, 4, 0, 0, 0, 0, 0, 65535);
        add_command(OP_SET_MODE, 4, 0, 0, 0, MODE_PULSE, 0, 0);
        add_command(OP_TICK, 9, 0, 0, 0, 0, 0, 0);
    endtask

    // mostly whole led programs (color, times, mode, then ticks), with
    // single random transactions mixed in as noise
    task automatic build_random();
        int added;
        int led;
        int ticks;
        int pick;
        added = 0;
        while (added < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) < 6) begin
                led   = $urandom_range(0, 15);
                ticks = $urandom_range(1, 4);
                pick  = $urandom_range(0, 9);
                add_command(OP_SET_COLOR, led, random_byte(), random_byte(), random_byte(),
                            $urandom_range(0, 3), random_ticks(), random_ticks());
                add_command(OP_SET_BLINK, led, random_byte(), random_byte(), random_byte(),
                            $urandom_range(0, 3), random_ticks(), random_ticks());
                add_command(OP_SET_MODE, led, random_byte(), random_byte(), random_byte(),
                            (pick < 4) ? MODE_BLINK : (pick < 8) ? MODE_PULSE : pick - 8,
                            random_ticks(), random_ticks());
                repeat (ticks)
                    add_command(OP_TICK, $urandom_range(0, 15), random_byte(), random_byte(),
                                random_byte(), $urandom_range(0, 3), random_ticks(),
                                random_ticks());
                added += 3 + ticks;
            end else begin
                add_random_command();
                added++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // driver: one command in flight on the ports, idle bursts between them
    // ------------------------------------------------------------------
    t_command cur_cmd;
    bit       took_cmd;
    bit       start_next;
    bit       quiet            = 1'b0;
    bit       gap_after_accept = 1'b0;
    int       gap_left         = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            took_cmd   = start && !busy;
            start_next = start && !took_cmd;
            if (took_cmd) begin
                apply_command(cur_cmd);
                accepted_count++;
                // switch between idling and back-to-back stretches now and then
                if ($urandom_range(0, 19) == 0)
                    quiet = !quiet;
                if (!quiet && accepted_count < total_items - TAIL_ITEMS &&
                        $urandom_range(0, 2) == 0) begin
                    gap_left         = $urandom_range(1, 19);
                    // counted from acceptance the gap mostly hides inside the
                    // block's work; counted from idle it always shows
                    gap_after_accept = $urandom_range(0, 1);
                end
            end
            if (!start_next) begin
                if (gap_left > 0) begin
                    if (gap_after_accept || !busy)
                        gap_left--;
                end else if (pending_commands.size() != 0) begin
                    cur_cmd      = pending_commands.pop_front();
                    i_operation  <= cur_cmd.op;
                    i_led_index  <= cur_cmd.led;
                    i_red        <= cur_cmd.red;
                    i_green      <= cur_cmd.green;
                    i_blue       <= cur_cmd.blue;
                    i_mode_value <= cur_cmd.mode;
                    i_on_ticks   <= cur_cmd.on_t;
                    i_off_ticks  <= cur_cmd.off_t;
                    start_next   = 1'b1;
                end
            end
            start <= start_next;
        end
    end

    // ------------------------------------------------------------------
    // monitor: every strobed byte against the oldest prediction
    // ------------------------------------------------------------------
    t_channel_beat want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (expected_channels.size() == 0) begin
                report_mismatch($sformatf("unexpected channel %0d byte %0h",
                                          o_channel_index, o_channel_byte));
            end else begin
                want = expected_channels.pop_front();
                if (o_channel_index !== want.chan_idx)
                    report_mismatch($sformatf("channel index %0d, want %0d",
                                              o_channel_index, want.chan_idx));
                if (o_channel_byte !== want.data)
                    report_mismatch($sformatf("channel %0d byte %0h, want %0h",
                                              want.chan_idx, o_channel_byte, want.data));
                if (o_last_channel !== want.last)
                    report_mismatch($sformatf("channel %0d last flag %0b, want %0b",
                                              want.chan_idx, o_last_channel, want.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // run control
    // ------------------------------------------------------------------
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin
        build_directed();
        build_random();
        total_items = pending_commands.size();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // polled on the falling edge, clear of the driver and monitor
        while (accepted_count != total_items)
            @(negedge i_clk);
        while (expected_channels.size() != 0)
            @(negedge i_clk);
        // a trailing write may still be working
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
`default_nettype wire
